[rtl/core/ple_pkg.sv]
// ple_pkg: shared constants, codes and the command type broadcast to the cell row.
// No dependencies; imported by every module of the list engine.
`default_nettype none

package ple_pkg;

  // List geometry
  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);  // holds 0..CAPACITY
  localparam int IDX_W    = $clog2(CAPACITY);      // addresses one cell
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int STAT_W   = 2;

  // Opcodes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT   = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK    = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT_AFTER = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT    = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK     = 3'd4;
  localparam logic [OP_W-1:0] OP_DELETE_INDEX = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Command seen by every cell in the row
  typedef struct packed {
    logic                     ins;    // open a gap at idx and load value
    logic                     del;    // close the gap at idx
    logic [CNT_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/core/ple_cell.sv]
// ple_cell: one storage cell of the list row; holds one word and shifts with its neighbors.
// Depends on ple_pkg.
`default_nettype none

module ple_cell (
  input  wire                               clk,
  input  ple_pkg::cell_cmd_t                cmd,
  input  wire        [ple_pkg::IDX_W-1:0]   cell_idx,
  input  wire signed [ple_pkg::DATA_W-1:0]  left_data,
  input  wire signed [ple_pkg::DATA_W-1:0]  right_data,
  output logic signed [ple_pkg::DATA_W-1:0] data_q,
  output logic signed [ple_pkg::DATA_W-1:0] tap
);
  import ple_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic [CNT_W-1:0]         my_idx;
  logic                     at_idx;
  logic                     above_idx;

  assign my_idx    = {1'b0, cell_idx};
  assign at_idx    = (my_idx == cmd.idx);
  assign above_idx = (my_idx > cmd.idx);

  // Insert: cells past the gap take the left word, the gap takes the new word.
  // Delete: the removed cell and all past it take the right word.
  // No command for this cell: hold.
  always_comb begin
    priority if (cmd.ins && at_idx) begin
      data_nxt = cmd.value;
    end else if (cmd.ins && above_idx) begin
      data_nxt = left_data;
    end else if (cmd.del && (at_idx || above_idx)) begin
      data_nxt = right_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  // Word offered to the removal bus only by the cell being deleted
  assign tap    = (cmd.del && at_idx) ? data_r : '0;

endmodule

`default_nettype wire

[rtl/core/ple_ctrl.sv]
// ple_ctrl: decodes a command against the current length into status, new length
// and the cell-row command. Depends on ple_pkg.
`default_nettype none

module ple_ctrl (
  input  wire        [ple_pkg::OP_W-1:0]    opcode,
  input  wire signed [ple_pkg::DATA_W-1:0]  value,
  input  wire        [ple_pkg::POS_W-1:0]   position,
  input  wire        [ple_pkg::CNT_W-1:0]   count,
  input  wire                               fire,
  output ple_pkg::cell_cmd_t                cmd,
  output logic       [ple_pkg::STAT_W-1:0]  status,
  output logic       [ple_pkg::CNT_W-1:0]   count_nxt
);
  import ple_pkg::*;

  logic             ins;
  logic             del;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pos_ext;
  logic             full;
  logic             empty;
  logic             out_of_range;

  assign pos_ext      = CNT_W'(position);
  assign full         = (count == CNT_W'(CAPACITY));
  assign empty        = (count == '0);
  assign out_of_range = (pos_ext >= count);

  // Full/empty checked ahead of position
  always_comb begin
    status = ST_OK;
    ins    = 1'b0;
    del    = 1'b0;
    idx    = '0;
    unique case (opcode)
      OP_PUSH_FRONT: begin
        if (full) status = ST_FULL;
        else      ins = 1'b1;
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ins = 1'b1;
          idx = count;
        end
      end
      OP_INSERT_AFTER: begin
        if (full)              status = ST_FULL;
        else if (empty)        status = ST_EMPTY;
        else if (out_of_range) status = ST_RANGE;
        else begin
          ins = 1'b1;
          idx = pos_ext + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) status = ST_EMPTY;
        else       del = 1'b1;
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          del = 1'b1;
          idx = count - CNT_W'(1);
        end
      end
      OP_DELETE_INDEX: begin
        if (empty)             status = ST_EMPTY;
        else if (out_of_range) status = ST_RANGE;
        else begin
          del = 1'b1;
          idx = pos_ext;
        end
      end
      default: ;  // unused codes: no operation
    endcase
  end

  always_comb begin
    if (ins)      count_nxt = count + CNT_W'(1);
    else if (del) count_nxt = count - CNT_W'(1);
    else          count_nxt = count;
  end

  // Cells only move on an accepted item
  assign cmd.ins   = ins & fire;
  assign cmd.del   = del & fire;
  assign cmd.idx   = idx;
  assign cmd.value = value;

endmodule

`default_nettype wire

[rtl/core/positional_list_engine.sv]
// positional_list_engine: top level of the bounded positional list; a row of shifting cells.
// Depends on ple_pkg, ple_ctrl and ple_cell.
//
//   channel | ports                                       | direction
//   in      | in_valid/in_ready, opcode, value, position  | command items in
//   out     | out_valid/out_ready, status, removed_value, | one result item per command
//           | length_after                                |
//
// Each item is decoded and applied to all cells in the cycle it is accepted.
// The result sits in an output register; a new item is taken while it is empty or out_ready is high.
// A stalled output holds in_ready low until the result is taken.
// Synchronous active-low reset empties the list; stored words are not cleared.
`default_nettype none

module positional_list_engine (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire        [ple_pkg::OP_W-1:0]     in_opcode,
  input  wire signed [ple_pkg::DATA_W-1:0]   in_value,
  input  wire        [ple_pkg::POS_W-1:0]    in_position,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic       [ple_pkg::STAT_W-1:0]   out_status,
  output logic signed [ple_pkg::DATA_W-1:0]  out_removed_value,
  output logic       [ple_pkg::CNT_W-1:0]    out_length_after
);
  import ple_pkg::*;

  logic                     accept;
  cell_cmd_t                cmd;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_tap  [CAPACITY];
  logic signed [DATA_W-1:0] removed;

  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic signed [DATA_W-1:0] out_removed_r;
  logic [CNT_W-1:0]         out_length_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Command decode
  ple_ctrl u_ctrl (
    .opcode    (in_opcode),
    .value     (in_value),
    .position  (in_position),
    .count     (count_r),
    .fire      (accept),
    .cmd       (cmd),
    .status    (status),
    .count_nxt (count_nxt)
  );

  // Cell row, front at index 0
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cell_idx   (IDX_W'(g)),
      .left_data  (left_w),
      .right_data (right_w),
      .data_q     (cell_data[g]),
      .tap        (cell_tap[g])
    );
  end

  // Removal bus: only the deleted cell drives a nonzero tap
  always_comb begin
    removed = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed = removed | cell_tap[i];
    end
  end

  // Length and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status;
      out_removed_r <= removed;
      out_length_r  <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_length_after  = out_length_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  a_len_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_length_r == count_r)
    else $error("reported length differs from stored length");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FULL) |-> out_length_r == CNT_W'(CAPACITY))
    else $error("full status with list not full");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_EMPTY) |-> out_length_r == '0)
    else $error("empty status with list not empty");

  a_fail_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_removed_r == '0)
    else $error("failed command returned a word");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (count_r == '0 && !out_valid_r))
    else $error("reset did not empty the list");

endmodule

`default_nettype wire
